[rtl/winner_tree_k_way_merge_defines.svh]
// Assertion helpers for the merge block.
// Each check is clocked on i_clk and masked while i_rst_n is low.
`ifndef WINNER_TREE_K_WAY_MERGE_DEFINES_SVH
`define WINNER_TREE_K_WAY_MERGE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define WTKM_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WTKM_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/wtkm_pkg.sv]
package wtkm_pkg;

    // Per-leaf state of the tournament
    typedef enum logic [1:0] {
        LEAF_AWAIT = 2'd0,
        LEAF_FULL  = 2'd1,
        LEAF_DONE  = 2'd2
    } t_leaf_st;

    // Control sequencer, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // Stream field widths and tuser bit positions
    localparam int IDX_BITS  = 3;
    localparam int DATA_BITS = 32;
    localparam int IN_USER_BITS  = 4;
    localparam int OUT_USER_BITS = 5;
    localparam int IN_DONE_BIT   = 3;
    localparam int OUT_DONE_BIT  = 3;
    localparam int OUT_ERR_BIT   = 4;

endpackage

[rtl/wtkm_ram.sv]
module wtkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/wtkm_play.sv]
module wtkm_play
    import wtkm_pkg::*;
#(
    parameter int LW = 3,
    parameter int KB = 32
) (
    input  logic [LW-1:0] i_a_idx,
    input  logic [KB-1:0] i_a_key,
    input  t_leaf_st      i_a_st,
    input  logic          i_a_real,
    input  logic [LW-1:0] i_b_idx,
    input  logic [KB-1:0] i_b_key,
    input  t_leaf_st      i_b_st,
    input  logic          i_b_real,
    output logic [LW-1:0] o_idx,
    output logic [KB-1:0] o_key
);

    logic w_a_ok;
    logic w_b_ok;
    logic w_take_b;

    // A contestant counts only if it covers real leaves and its leaf holds a key
    assign w_a_ok = i_a_real && (i_a_st == LEAF_FULL);
    assign w_b_ok = i_b_real && (i_b_st == LEAF_FULL);

    // Left side (a) wins ties
    always_comb begin
        priority if (!w_b_ok) begin
            w_take_b = 1'b0;
        end else if (!w_a_ok) begin
            w_take_b = 1'b1;
        end else begin
            w_take_b = ($signed(i_b_key) < $signed(i_a_key));
        end
    end

    assign o_idx = w_take_b ? i_b_idx : i_a_idx;
    assign o_key = w_take_b ? i_b_key : i_a_key;

endmodule

[rtl/winner_tree_k_way_merge.sv]
// Key item: accepted in ST_IDLE, then one ST_WALK match per tree level (log2 WAYS, padded);
// at the root the result enters the output register if it is free, else waits in ST_EMIT,
// and none is emitted while any leaf awaits a key. Rejected and all-exhausted items: accept, then ST_EMIT load.
// The walk is bound by one read of the tree memory per level (registered read port).
// i_rst_n (synchronous, active low) clears the sequencer, output valid and leaf states
// to awaiting; the tree memory is not cleared, every entry is rewritten before it matters.
module winner_tree_k_way_merge
    import wtkm_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int KEY_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [DATA_BITS-1:0]     s_axis_tdata,   // [31:0] record_key
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,   // [2:0] source_index, [3] source_done
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [DATA_BITS-1:0]     m_axis_tdata,   // [31:0] winner_key
    output logic [OUT_USER_BITS-1:0] m_axis_tuser    // [2:0] winner_source, [3] merge_done,
                                                     // [4] protocol_error
);

`include "winner_tree_k_way_merge_defines.svh"

    localparam int LW  = $clog2(WAYS);
    localparam int P   = 1 << LW;
    localparam int AW  = LW + 1;
    localparam int KB  = (KEY_BITS < DATA_BITS) ? KEY_BITS : DATA_BITS;
    localparam int EW  = LW + KB;
    localparam int LVW = (LW > 1) ? $clog2(LW) : 1;

    t_state              r_state, n_state;
    t_leaf_st            r_status [WAYS];
    t_leaf_st            n_status [WAYS];
    t_leaf_st            w_st_upd [WAYS];
    logic [AW-1:0]       r_node, n_node;
    logic [LVW-1:0]      r_lvl, n_lvl;
    logic [LW-1:0]       r_cidx, n_cidx;
    logic [KB-1:0]       r_ckey, n_ckey;
    logic                r_emit, n_emit;
    logic [KB-1:0]       r_pend_key, n_pend_key;
    logic [LW-1:0]       r_pend_src, n_pend_src;
    logic                r_pend_done, n_pend_done;
    logic                r_pend_err, n_pend_err;
    logic                r_out_valid, n_out_valid;
    logic [DATA_BITS-1:0]     r_out_key, n_out_key;
    logic [OUT_USER_BITS-1:0] r_out_user, n_out_user;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    logic [IDX_BITS-1:0] w_in_idx;
    logic                w_in_done;
    logic [KB-1:0]       w_in_key;
    logic [LW-1:0]       w_leaf;
    logic                w_in_range;
    t_leaf_st            w_leaf_st;
    logic                w_bad;
    logic                w_in_acc;
    logic                w_any_wait;
    logic                w_all_done;
    logic                w_out_free;

    logic [AW-1:0]       w_sib;
    logic [AW-1:0]       w_sib_first;
    logic                w_sib_real;
    logic [LW-1:0]       w_sib_idx;
    logic [KB-1:0]       w_sib_key;
    t_leaf_st            w_sib_st;
    t_leaf_st            w_c_st;
    logic [AW-1:0]       w_parent;
    logic                w_at_root;
    logic [LW-1:0]       w_a_idx, w_b_idx;
    logic [KB-1:0]       w_a_key, w_b_key;
    t_leaf_st            w_a_st, w_b_st;
    logic                w_a_real, w_b_real;
    logic [LW-1:0]       w_win_idx;
    logic [KB-1:0]       w_win_key;

    // Tree memory: entry n holds {winning leaf, its key}; leaves sit at P + leaf
    wtkm_ram #(
        .WIDTH(EW),
        .DEPTH(2 * P)
    ) u_tree (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Decode the incoming item
    assign w_in_idx   = s_axis_tuser[IDX_BITS-1:0];
    assign w_in_done  = s_axis_tuser[IN_DONE_BIT];
    assign w_in_key   = s_axis_tdata[KB-1:0];
    assign w_leaf     = LW'(w_in_idx);
    assign w_in_range = (int'(w_in_idx) < WAYS);
    assign w_leaf_st  = w_in_range ? r_status[w_leaf] : LEAF_DONE;
    assign w_bad      = (w_leaf_st != LEAF_AWAIT);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;

    // Leaf states after this item, and what they say about the merge
    always_comb begin
        w_st_upd = r_status;
        if (!w_bad) begin
            w_st_upd[w_leaf] = w_in_done ? LEAF_DONE : LEAF_FULL;
        end
        w_any_wait = 1'b0;
        w_all_done = 1'b1;
        for (int i = 0; i < WAYS; i++) begin
            if (w_st_upd[i] == LEAF_AWAIT) begin
                w_any_wait = 1'b1;
            end
            if (w_st_upd[i] != LEAF_DONE) begin
                w_all_done = 1'b0;
            end
        end
    end

    // One match per level: the carried winner against the sibling entry just read
    assign {w_sib_idx, w_sib_key} = ram_rdata;
    assign w_sib       = r_node ^ AW'(1);
    assign w_sib_first = w_sib << r_lvl;
    assign w_sib_real  = ({1'b0, w_sib_first} < (AW + 1)'(P + WAYS));
    assign w_sib_st    = (int'(w_sib_idx) < WAYS) ? r_status[w_sib_idx] : LEAF_AWAIT;
    assign w_c_st      = (int'(r_cidx) < WAYS) ? r_status[r_cidx] : LEAF_AWAIT;
    assign w_parent    = r_node >> 1;
    assign w_at_root   = (w_parent == AW'(1));

    always_comb begin
        if (r_node[0]) begin
            w_a_idx  = w_sib_idx;
            w_a_key  = w_sib_key;
            w_a_st   = w_sib_st;
            w_a_real = w_sib_real;
            w_b_idx  = r_cidx;
            w_b_key  = r_ckey;
            w_b_st   = w_c_st;
            w_b_real = 1'b1;
        end else begin
            w_a_idx  = r_cidx;
            w_a_key  = r_ckey;
            w_a_st   = w_c_st;
            w_a_real = 1'b1;
            w_b_idx  = w_sib_idx;
            w_b_key  = w_sib_key;
            w_b_st   = w_sib_st;
            w_b_real = w_sib_real;
        end
    end

    wtkm_play #(
        .LW(LW),
        .KB(KB)
    ) u_play (
        .i_a_idx (w_a_idx),
        .i_a_key (w_a_key),
        .i_a_st  (w_a_st),
        .i_a_real(w_a_real),
        .i_b_idx (w_b_idx),
        .i_b_key (w_b_key),
        .i_b_st  (w_b_st),
        .i_b_real(w_b_real),
        .o_idx   (w_win_idx),
        .o_key   (w_win_key)
    );

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Sequencer: accept, walk leaf to root, hand the result to the output register
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_node      = r_node;
        n_lvl       = r_lvl;
        n_cidx      = r_cidx;
        n_ckey      = r_ckey;
        n_emit      = r_emit;
        n_pend_key  = r_pend_key;
        n_pend_src  = r_pend_src;
        n_pend_done = r_pend_done;
        n_pend_err  = r_pend_err;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_key   = r_out_key;
        n_out_user  = r_out_user;
        ram_we      = 1'b0;
        ram_waddr   = w_parent;
        ram_wdata   = {w_win_idx, w_win_key};
        ram_raddr   = w_parent ^ AW'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    priority if (w_bad) begin
                        // drop the item, report it
                        n_pend_key  = '0;
                        n_pend_src  = '0;
                        n_pend_done = 1'b0;
                        n_pend_err  = 1'b1;
                        n_state     = ST_EMIT;
                    end else if (w_all_done) begin
                        // every stream exhausted: rearm all leaves
                        for (int i = 0; i < WAYS; i++) begin
                            n_status[i] = LEAF_AWAIT;
                        end
                        n_pend_key  = '0;
                        n_pend_src  = '0;
                        n_pend_done = 1'b1;
                        n_pend_err  = 1'b0;
                        n_state     = ST_EMIT;
                    end else begin
                        // store the leaf, fetch its sibling, start the walk
                        n_status  = w_st_upd;
                        ram_we    = 1'b1;
                        ram_waddr = {1'b1, w_leaf};
                        ram_wdata = {w_leaf, w_in_key};
                        ram_raddr = {1'b1, w_leaf ^ LW'(1)};
                        n_node    = {1'b1, w_leaf};
                        n_lvl     = '0;
                        n_cidx    = w_leaf;
                        n_ckey    = w_in_key;
                        n_emit    = !w_any_wait;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // write the parent, move up, fetch the next sibling
                ram_we = 1'b1;
                n_cidx = w_win_idx;
                n_ckey = w_win_key;
                n_node = w_parent;
                n_lvl  = r_lvl + LVW'(1);
                if (w_at_root) begin
                    if (!r_emit) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_status[w_win_idx] = LEAF_AWAIT;
                        n_pend_key  = w_win_key;
                        n_pend_src  = w_win_idx;
                        n_pend_done = 1'b0;
                        n_pend_err  = 1'b0;
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_key   = DATA_BITS'($signed(w_win_key));
                            n_out_user  = {1'b0, 1'b0, IDX_BITS'(w_win_idx)};
                            n_state     = ST_IDLE;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                // hold the result until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = DATA_BITS'($signed(r_pend_key));
                    n_out_user  = {r_pend_err, r_pend_done, IDX_BITS'(r_pend_src)};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WAYS; i++) begin
                r_status[i] <= LEAF_AWAIT;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_lvl       <= n_lvl;
        r_cidx      <= n_cidx;
        r_ckey      <= n_ckey;
        r_emit      <= n_emit;
        r_pend_key  <= n_pend_key;
        r_pend_src  <= n_pend_src;
        r_pend_done <= n_pend_done;
        r_pend_err  <= n_pend_err;
        r_out_key   <= n_out_key;
        r_out_user  <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_key;
    assign m_axis_tuser  = r_out_user;

    // The walk pointer always sits at the depth that matches its level count
    `WTKM_HOLDS(a_walk_depth, r_state == ST_WALK, (r_node >> (LW - int'(r_lvl))) == AW'(1), "walk node and level disagree")

    // A rejected item goes straight to reporting
    `WTKM_NEXT(a_bad_reported, w_in_acc && w_bad, (r_state == ST_EMIT) && r_pend_err, "rejected item not reported")

    // The emitted winner leaf waits for its refill
    `WTKM_NEXT(a_winner_rearmed, (r_state == ST_WALK) && w_at_root && r_emit, r_status[$past(w_win_idx)] == LEAF_AWAIT, "winner leaf not rearmed")

endmodule
